// File: rtl/trace_pulse_analyzer_unit_macros.svh
// Assertion macros shared by the trace pulse analyzer RTL.
`ifndef TRACE_PULSE_ANALYZER_UNIT_MACROS_SVH
`define TRACE_PULSE_ANALYZER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define TPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");
// Check a property on every clock edge, reset included.
`define TPA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("%m: assertion failed");
`else
`define TPA_ASSERT(lbl, prop)
`define TPA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: rtl/tpa_pkg.sv
// Package with widths, constants and types of the trace pulse analyzer.
package tpa_pkg;

  localparam int SAMPLE_W    = 14;
  localparam int DEPTH_W     = 14;
  localparam int GAP_W       = 10;
  localparam int AMP_W       = 18;
  localparam int IDX_W       = 10;

  localparam int PREGATE     = 25;
  localparam int LAG         = 6;
  localparam int MAX_SAMPLES = 1024;
  localparam int WIN_LEN     = 2 * LAG;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int POS_W  = $clog2(MAX_SAMPLES);
  localparam int SUM_W  = $clog2(PREGATE * ((1 << SAMPLE_W) - 1) + 1);
  localparam int FRAC_W = 4;
  localparam int NUM_W  = SUM_W + FRAC_W;
  localparam int MIN16_W = SAMPLE_W + FRAC_W;

  // Reciprocal of PREGATE, scaled by 2^RECIP_SHIFT; quotient estimate is q or q-1
  localparam int RECIP_SHIFT = NUM_W;
  localparam int RECIP_W     = RECIP_SHIFT - $clog2(PREGATE) + 1;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / PREGATE);

  localparam logic [DEPTH_W-1:0] VALLEY_DEPTH_RST = DEPTH_W'(50);
  localparam logic [GAP_W-1:0]   PULSE_GAP_RST    = GAP_W'(30);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = (DEPTH_W > GAP_W) ? DEPTH_W : GAP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VALLEY_DEPTH = 1'b0,
    CFG_PULSE_GAP    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [DEPTH_W-1:0] valley_depth;
    logic [GAP_W-1:0]   pulse_gap;
  } cfg_t;

  // Final per-trace state handed to the result pipeline
  typedef struct packed {
    logic [SUM_W-1:0]    base_sum;
    logic [SAMPLE_W-1:0] min_value;
    logic [POS_W-1:0]    min_pos;
    logic                pileup;
  } fin_t;

endpackage

// File: rtl/tpa_trace_acc.sv
// Per-sample trace state: baseline sum, first minimum, valley scan and pileup.
`include "trace_pulse_analyzer_unit_macros.svh"

module tpa_trace_acc (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tpa_pkg::cfg_t            cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [tpa_pkg::SAMPLE_W-1:0] in_sample_i,
  input  logic                     in_last_i,
  output logic                     fin_valid_o,
  input  logic                     fin_ready_i,
  output tpa_pkg::fin_t            fin_o
);
  import tpa_pkg::*;

  localparam int CMP_W = (POS_W > GAP_W) ? POS_W : GAP_W;

  logic                in_vld_q;
  logic [SAMPLE_W-1:0] in_sample_q;
  logic                in_last_q;

  logic [SAMPLE_W-1:0] win_q [WIN_LEN];
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SUM_W-1:0]    sum_q, sum_upd;
  logic [SAMPLE_W-1:0] min_q, min_upd;
  logic [POS_W-1:0]    pos_q, pos_upd;
  logic [POS_W-1:0]    lv_q, lv_upd;
  logic                vseen_q, vseen_upd;
  logic                pile_q, pile_upd;

  logic                fire, take, scan, valley;
  logic [SAMPLE_W:0]   thresh;
  logic [POS_W-1:0]    centre, gap_diff;

  assign fire       = in_vld_q && (!in_last_q || fin_ready_i);
  assign in_ready_o = !in_vld_q || fire;
  assign take       = fire && (cnt_q < CNT_W'(MAX_SAMPLES));
  assign scan       = cnt_q >= CNT_W'(WIN_LEN);

  // Both lag neighbors must exceed the centre by more than the depth
  assign thresh   = {1'b0, win_q[LAG-1]} + (SAMPLE_W+1)'(cfg_i.valley_depth);
  assign valley   = scan &&
                    ({1'b0, win_q[WIN_LEN-1]} > thresh) &&
                    ({1'b0, in_sample_q} > thresh);
  assign centre   = POS_W'(cnt_q - CNT_W'(LAG));
  assign gap_diff = centre - lv_q;

  always_comb begin
    sum_upd   = sum_q;
    min_upd   = min_q;
    pos_upd   = pos_q;
    lv_upd    = lv_q;
    vseen_upd = vseen_q;
    pile_upd  = pile_q;
    if (take) begin
      if (cnt_q < CNT_W'(PREGATE)) begin
        sum_upd = sum_q + SUM_W'(in_sample_q);
      end
      if (cnt_q == '0 || in_sample_q < min_q) begin
        min_upd = in_sample_q;
        pos_upd = POS_W'(cnt_q);
      end
      if (valley) begin
        if (vseen_q && (CMP_W'(gap_diff) > CMP_W'(cfg_i.pulse_gap))) begin
          pile_upd = 1'b1;
        end
        lv_upd    = centre;
        vseen_upd = 1'b1;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (fire) begin
      if (in_last_q) begin
        cnt_d = '0;
      end else if (take) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  assign fin_valid_o    = in_vld_q && in_last_q;
  assign fin_o.base_sum = sum_upd;
  assign fin_o.min_value = min_upd;
  assign fin_o.min_pos  = pos_upd;
  assign fin_o.pileup   = pile_upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_sample_q <= in_sample_i;
      in_last_q   <= in_last_i;
    end
  end

  // Window holds data only; scan waits until it is full within the trace
  always_ff @(posedge clk_i) begin
    if (take) begin
      win_q[0] <= in_sample_q;
      for (int i = 1; i < WIN_LEN; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sum_q   <= '0;
      min_q   <= '1;
      pos_q   <= '0;
      lv_q    <= '0;
      vseen_q <= 1'b0;
      pile_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (fire && in_last_q) begin
        sum_q   <= '0;
        min_q   <= '1;
        pos_q   <= '0;
        lv_q    <= '0;
        vseen_q <= 1'b0;
        pile_q  <= 1'b0;
      end else begin
        sum_q   <= sum_upd;
        min_q   <= min_upd;
        pos_q   <= pos_upd;
        lv_q    <= lv_upd;
        vseen_q <= vseen_upd;
        pile_q  <= pile_upd;
      end
    end
  end

  `TPA_ASSERT(cnt_clear_after_last_a, fire && in_last_q |=> cnt_q == '0)
  `TPA_ASSERT(min_pos_in_trace_a, cnt_q != '0 |-> CNT_W'(pos_q) < cnt_q)

endmodule

// File: rtl/tpa_result.sv
// Result pipeline: baseline mean by reciprocal multiply, amplitude, output register.
`include "trace_pulse_analyzer_unit_macros.svh"

module tpa_result (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fin_valid_i,
  output logic                     fin_ready_o,
  input  tpa_pkg::fin_t            fin_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [tpa_pkg::AMP_W-1:0] out_amp_o,
  output logic [tpa_pkg::IDX_W-1:0] out_idx_o,
  output logic                     out_pileup_o
);
  import tpa_pkg::*;

  localparam int CMP_W = (Q_W + 1 > MIN16_W) ? Q_W + 1 : MIN16_W;

  logic                a_vld_q, b_vld_q, out_vld_q;
  logic                a_rdy, b_rdy, c_rdy;
  fin_t                a_q;

  logic [PROD_W-1:0]   prod;
  logic [NUM_W-1:0]    a_num;
  logic [NUM_W-1:0]    b_num_q;
  logic [Q_W-1:0]      b_qest_q;
  logic [MIN16_W-1:0]  b_min16_q;
  logic [POS_W-1:0]    b_pos_q;
  logic                b_pile_q;

  logic [Q_W:0]        q1;
  logic [NUM_W:0]      q1_mul;
  logic [CMP_W-1:0]    mean, min16;
  logic [CMP_W-1:0]    amp;

  logic [AMP_W-1:0]    amp_q;
  logic [IDX_W-1:0]    idx_q;
  logic                pile_q;

  assign c_rdy       = !out_vld_q || out_ready_i;
  assign b_rdy       = !b_vld_q || c_rdy;
  assign a_rdy       = !a_vld_q || b_rdy;
  assign fin_ready_o = a_rdy;

  // Stage B: estimate of floor(16 * sum / PREGATE), low by at most one
  assign a_num = {a_q.base_sum, {FRAC_W{1'b0}}};
  assign prod  = PROD_W'(a_num) * PROD_W'(RECIP);

  // Stage C: correct the estimate, subtract the minimum, clamp at zero
  assign q1     = {1'b0, b_qest_q} + (Q_W+1)'(1);
  assign q1_mul = (NUM_W+1)'(q1) * (NUM_W+1)'(PREGATE);
  assign mean   = (q1_mul <= {1'b0, b_num_q}) ? CMP_W'(q1) : CMP_W'(b_qest_q);
  assign min16  = CMP_W'(b_min16_q);
  assign amp    = (mean > min16) ? (mean - min16) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_q <= fin_valid_i;
      end
      if (b_rdy) begin
        b_vld_q <= a_vld_q;
      end
      if (c_rdy) begin
        out_vld_q <= b_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && fin_valid_i) begin
      a_q <= fin_i;
    end
    if (b_rdy && a_vld_q) begin
      b_num_q   <= a_num;
      b_qest_q  <= prod[PROD_W-1:RECIP_SHIFT];
      b_min16_q <= {a_q.min_value, {FRAC_W{1'b0}}};
      b_pos_q   <= a_q.min_pos;
      b_pile_q  <= a_q.pileup;
    end
    if (c_rdy && b_vld_q) begin
      amp_q  <= AMP_W'(amp);
      idx_q  <= IDX_W'(b_pos_q);
      pile_q <= b_pile_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_amp_o    = amp_q;
  assign out_idx_o    = idx_q;
  assign out_pileup_o = pile_q;

  `TPA_ASSERT(out_load_a, b_vld_q && c_rdy |=> out_vld_q)
  `TPA_ASSERT(out_drain_a, out_vld_q && out_ready_i && !b_vld_q |=> !out_vld_q)

endmodule

// File: rtl/trace_pulse_analyzer_unit.sv
// Top level of the trace pulse analyzer: config registers, trace state, result pipeline.
//
// Usage: stream one detector trace into the slave channel, one 14-bit sample
// per item in s_axis_tdata_i, with s_axis_tlast_i high on the final sample.
// For every trace the master channel returns one item: the amplitude
// (baseline mean over the first pregate samples minus the first minimum,
// 4 fraction bits) and the index of that minimum in m_axis_tdata_o, and the
// pileup flag in m_axis_tuser_o. Samples that carry no tlast return nothing.
// Throughput: one sample per clock, traces back to back with no gap, while
// the result pipeline can take each last sample. Path: a last sample passes
// the input register, then handoff register, reciprocal multiply for the
// mean, correction and subtract into the output register (m_axis_tvalid_o).
// Stall: while the receiver holds m_axis_tready_i low the result waits in the
// output register; samples keep flowing, two later results wait in the
// pipeline, and a third last sample held in the input register drops
// s_axis_tready_o until the pipeline advances again.
// Config: write valley_depth (index 0) and pulse_gap (index 1) through
// cfg_we_i while the block is idle; writes take effect at once.
// Reset: rst_ni clears all valid flags and the per-trace state, and loads
// valley_depth = 50 and pulse_gap = 30.
`include "trace_pulse_analyzer_unit_macros.svh"

module trace_pulse_analyzer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Config write port
  input  logic                          cfg_we_i,
  input  logic [tpa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tpa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Sample stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [15:0]                   s_axis_tdata_i,  // [13:0] sample, [15:14] zero
  input  logic                          s_axis_tlast_i,  // last_sample
  // Result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [31:0]                   m_axis_tdata_o,  // [17:0] amplitude,
                                                         // [27:18] peak_index, [31:28] zero
  output logic                          m_axis_tuser_o   // pileup
);
  import tpa_pkg::*;

  cfg_t                cfg_q;
  logic                fin_valid, fin_ready;
  fin_t                fin;
  logic [AMP_W-1:0]    out_amp;
  logic [IDX_W-1:0]    out_idx;

  // Config registers: write index selects the register, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.valley_depth <= VALLEY_DEPTH_RST;
      cfg_q.pulse_gap    <= PULSE_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_VALLEY_DEPTH: cfg_q.valley_depth <= DEPTH_W'(cfg_wdata_i);
        CFG_PULSE_GAP:    cfg_q.pulse_gap    <= GAP_W'(cfg_wdata_i);
        default: begin
        end
      endcase
    end
  end

  // Per-sample state; hands the final trace state over on tlast
  tpa_trace_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_sample_i (s_axis_tdata_i[SAMPLE_W-1:0]),
    .in_last_i   (s_axis_tlast_i),
    .fin_valid_o (fin_valid),
    .fin_ready_i (fin_ready),
    .fin_o       (fin)
  );

  // Mean, amplitude and the output register
  tpa_result u_res (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fin_valid_i  (fin_valid),
    .fin_ready_o  (fin_ready),
    .fin_i        (fin),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_amp_o    (out_amp),
    .out_idx_o    (out_idx),
    .out_pileup_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{(32 - AMP_W - IDX_W){1'b0}}, out_idx, out_amp};

  // The final trace state can only be handed over after a tlast sample came in
  `TPA_ASSERT(fin_needs_last_a, fin_valid && fin_ready |-> $past(s_axis_tlast_i) ||
              !$past(s_axis_tready_o))
  `TPA_ASSERT_ALWAYS(cfg_reset_a, !rst_ni |=> cfg_q.valley_depth == VALLEY_DEPTH_RST ||
                     rst_ni)

endmodule

// File: test/tb_trace_pulse_analyzer_unit.sv
// Testbench of the trace pulse analyzer: directed and random traces checked by a predictor.
`timescale 1ns / 100ps

module tb_trace_pulse_analyzer_unit;
  import tpa_pkg::*;

  // Slowest run: about 2000 samples under heavy idling, plus the long hold-off,
  // with a wide margin on top.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;  // receiver hold-off in the pressure phase
  localparam int DRAIN_CYCLES = 8;    // settle time after draining; leaves margin over the result pipeline
  localparam int PHASE_ITEMS  = 120;  // random samples per phase, long trace aside
  localparam int N_DIRECTED   = 20;

  typedef enum int {
    PH_DIRECTED,
    PH_OPEN,
    PH_SLOW_SOURCE,
    PH_SLOW_SINK,
    PH_BOTH,
    PH_PRESSURE,
    PH_LONG_TRACE
  } phase_e;

  typedef enum int {
    TR_PULSE,
    TR_NOISE
  } trace_kind_e;

  typedef struct packed {
    logic [AMP_W-1:0] amplitude;
    logic [IDX_W-1:0] peak_index;
    logic             pileup;
  } trace_result_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                typed;  // result below is typed in, not predicted
    trace_result_t       res;
  } directed_row_t;

  // Single-sample traces at both extremes, equal minima, a maximum baseline over
  // a zero minimum, then a 14-sample trace with one valley at the first centre
  // that the scan can reach.
  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{14'd16383, 1'b1, 1'b1, '{18'd0, 10'd0, 1'b0}},
    '{14'd0,     1'b1, 1'b1, '{18'd0, 10'd0, 1'b0}},
    '{14'd100,   1'b0, 1'b0, '0},
    '{14'd100,   1'b1, 1'b1, '{18'd0, 10'd0, 1'b0}},
    '{14'd16383, 1'b0, 1'b0, '0},
    '{14'd0,     1'b1, 1'b1, '{18'd10485, 10'd1, 1'b0}},
    '{14'd1000,  1'b0, 1'b0, '0},
    '{14'd1000,  1'b0, 1'b0, '0},
    '{14'd1000,  1'b0, 1'b0, '0},
    '{14'd1000,  1'b0, 1'b0, '0},
    '{14'd1000,  1'b0, 1'b0, '0},
    '{14'd1000,  1'b0, 1'b0, '0},
    '{14'd500,   1'b0, 1'b0, '0},
    '{14'd1000,  1'b0, 1'b0, '0},
    '{14'd1000,  1'b0, 1'b0, '0},
    '{14'd1000,  1'b0, 1'b0, '0},
    '{14'd1000,  1'b0, 1'b0, '0},
    '{14'd1000,  1'b0, 1'b0, '0},
    '{14'd1000,  1'b0, 1'b0, '0},
    '{14'd1000,  1'b1, 1'b0, '0}
  };

  logic                  clk_i;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_valid   = 1'b0;
  logic [15:0]           s_data    = '0;
  logic                  s_last    = 1'b0;
  logic                  m_ready   = 1'b0;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [31:0]           m_axis_tdata_o;
  logic                  m_axis_tuser_o;

  trace_pulse_analyzer_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Traffic shaping, set by the main sequence and read by the driver and receiver
  phase_e phase        = PH_DIRECTED;
  int     tx_idle_pct  = 0;
  int     rx_stall_pct = 0;

  // Predictor copy of the configuration and the per-trace state
  int unsigned depth_reg;
  int unsigned gap_reg;
  int unsigned win_hist [WIN_LEN];  // [0] holds the newest earlier sample
  int unsigned trace_len;
  int unsigned base_acc;
  int unsigned floor_val;
  int unsigned floor_pos;
  int unsigned prev_valley;
  bit          valley_hit;
  bit          pileup_hit;

  trace_result_t pending_results [$];

  int errors          = 0;
  int samples_sent    = 0;
  int traces_sent     = 0;
  int longest_trace   = 0;
  int results_checked = 0;
  int pileup_results  = 0;
  int input_stalls    = 0;
  int cycles          = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_trace_pulse_analyzer_unit NOT OK");
    $finish;
  end

  // Return the per-trace state to its reset value
  function automatic void clear_trace();
    foreach (win_hist[k]) win_hist[k] = 0;
    trace_len   = 0;
    base_acc    = 0;
    floor_val   = (1 << SAMPLE_W) - 1;
    floor_pos   = 0;
    prev_valley = 0;
    valley_hit  = 1'b0;
    pileup_hit  = 1'b0;
  endfunction

  // Advance the predicted trace state by one sample; return 1 with the result
  // when the sample closes the trace.
  function automatic bit analyze_sample(input logic [SAMPLE_W-1:0] smp, input logic lst,
                                        output trace_result_t res);
    int unsigned mid;
    int unsigned left;
    int unsigned centre;
    int unsigned mean16;
    int unsigned min16;
    res = '0;
    // Samples past the sample limit only count for their last mark
    if (trace_len < MAX_SAMPLES) begin
      if (trace_len < PREGATE) base_acc += smp;
      // Strict compare keeps the earliest of equal minima
      if (trace_len == 0 || smp < floor_val) begin
        floor_val = smp;
        floor_pos = trace_len;
      end
      // Scan the centre LAG samples back once both lag neighbors are inside
      if (trace_len >= WIN_LEN) begin
        mid    = win_hist[LAG-1];
        left   = win_hist[WIN_LEN-1];
        centre = trace_len - LAG;
        if (left > mid && smp > mid && left - mid > depth_reg && smp - mid > depth_reg) begin
          if (valley_hit && centre - prev_valley > gap_reg) pileup_hit = 1'b1;
          prev_valley = centre;
          valley_hit  = 1'b1;
        end
      end
      for (int k = WIN_LEN - 1; k > 0; k--) win_hist[k] = win_hist[k-1];
      win_hist[0] = smp;
      trace_len++;
    end
    if (!lst) return 1'b0;
    // Mean with 4 fraction bits, truncated; clamp a negative height at zero
    mean16 = (base_acc * 16) / PREGATE;
    min16  = floor_val * 16;
    res.amplitude  = (mean16 > min16) ? AMP_W'(mean16 - min16) : '0;
    res.peak_index = IDX_W'(floor_pos);
    res.pileup     = pileup_hit;
    clear_trace();
    return 1'b1;
  endfunction

  // Offer one sample, idling first at the configured rate, and hold it until
  // accepted. Queue the trace result when the sample closes a trace.
  task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic lst,
                             input bit typed, input trace_result_t typed_res);
    trace_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {2'b00, smp};
    s_last  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready_o) begin
      input_stalls++;
      @(posedge clk_i);
    end
    samples_sent++;
    if (analyze_sample(smp, lst, res)) begin
      pending_results.insert(pending_results.size(), typed ? typed_res : res);
    end
  endtask

  // Send a whole trace: a noisy baseline with a few negative dips, or raw noise
  // that hits the sample extremes often.
  task automatic send_trace(input trace_kind_e kind, input int len);
    int base;
    int noise;
    int npulse;
    int ppos [3];
    int pwid [3];
    int pdep [3];
    int v;
    base   = ($urandom_range(3) == 0) ? 16383 : int'($urandom_range(16383));
    noise  = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(1, 40));
    npulse = $urandom_range(3);
    for (int p = 0; p < 3; p++) begin
      ppos[p] = $urandom_range(len - 1);
      pwid[p] = $urandom_range(1, 8);
      pdep[p] = ($urandom_range(4) == 0) ? 16383 : int'($urandom_range(3000));
    end
    for (int i = 0; i < len; i++) begin
      if (kind == TR_NOISE) begin
        case ($urandom_range(3))
          0:       v = 0;
          1:       v = 16383;
          default: v = $urandom_range(16383);
        endcase
      end else begin
        v = base + int'($urandom_range(noise)) - noise / 2;
        for (int p = 0; p < npulse; p++) begin
          if (i >= ppos[p] && i < ppos[p] + pwid[p]) v -= pdep[p];
        end
        if (v < 0) v = 0;
        if (v > 16383) v = 16383;
      end
      push_sample(SAMPLE_W'(v), i == len - 1, 1'b0, '0);
    end
    traces_sent++;
    if (len > longest_trace) longest_trace = len;
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic drain_results();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Write both registers on back-to-back edges, then drop the write enable
  task automatic program_regs(input int unsigned depth, input int unsigned gap);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_VALLEY_DEPTH;
    cfg_wdata <= CFG_DATA_W'(depth);
    @(posedge clk_i);
    cfg_idx   <= CFG_PULSE_GAP;
    cfg_wdata <= CFG_DATA_W'(gap);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    depth_reg = depth;
    gap_reg   = gap;
  endtask

  // One random phase: settle, reprogram, set the traffic shape, then send traces
  // until the sample budget is spent.
  task automatic run_phase(input phase_e ph, input int unsigned depth, input int unsigned gap,
                           input int tx_pct, input int rx_pct);
    int start;
    int len;
    bit paused;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    program_regs(depth, gap);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    phase        = ph;
    paused       = 1'b0;
    // Run past the sample limit once
    if (ph == PH_LONG_TRACE) send_trace(TR_PULSE, MAX_SAMPLES + int'($urandom_range(1, 12)));
    start = samples_sent;
    while (samples_sent - start < PHASE_ITEMS) begin
      // Short traces under pressure so that results pile up behind the hold-off
      if (ph == PH_PRESSURE) len = $urandom_range(1, 3);
      else len = ($urandom_range(9) == 0) ? int'($urandom_range(61, 200))
                                            : int'($urandom_range(1, 60));
      send_trace(($urandom_range(4) == 0) ? TR_NOISE : TR_PULSE, len);
      // Pause the source once mid-phase until the block has emptied
      if (ph == PH_SLOW_SINK && !paused && samples_sent - start >= PHASE_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  // Receiver: check each accepted result against the oldest expectation, then
  // pick tready for the next cycle. Count the pressure hold-off here.
  initial begin
    trace_result_t want;
    logic [AMP_W-1:0] got_amp;
    logic [IDX_W-1:0] got_idx;
    int hold_count;
    hold_count = 0;
    forever begin
      @(posedge clk_i);
      if (rst_n && m_axis_tvalid_o && m_ready) begin
        got_amp = m_axis_tdata_o[AMP_W-1:0];
        got_idx = m_axis_tdata_o[AMP_W +: IDX_W];
        if (pending_results.size() == 0) begin
          $error("result with no trace pending: amplitude %0d peak_index %0d pileup %0b",
                 got_amp, got_idx, m_axis_tuser_o);
          errors++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (want.pileup) pileup_results++;
          if (got_amp !== want.amplitude) begin
            $error("amplitude: expected %0d, got %0d", want.amplitude, got_amp);
            errors++;
          end
          if (got_idx !== want.peak_index) begin
            $error("peak_index: expected %0d, got %0d", want.peak_index, got_idx);
            errors++;
          end
          if (m_axis_tuser_o !== want.pileup) begin
            $error("pileup: expected %0b, got %0b", want.pileup, m_axis_tuser_o);
            errors++;
          end
        end
      end
      if (phase == PH_PRESSURE && hold_count < HOLD_CYCLES) begin
        hold_count++;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Main sequence
  initial begin
    depth_reg = VALLEY_DEPTH_RST;
    gap_reg   = PULSE_GAP_RST;
    clear_trace();
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed rows run on the reset configuration
    for (int r = 0; r < N_DIRECTED; r++) begin
      push_sample(DIRECTED_ROWS[r].sample, DIRECTED_ROWS[r].last,
                  DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);
    end
    traces_sent += 5;

    run_phase(PH_OPEN,        0,     0,    0,  0);
    run_phase(PH_SLOW_SOURCE, 16383, 1023, 77, 0);
    run_phase(PH_SLOW_SINK,   200,   10,   0,  77);
    run_phase(PH_BOTH,        $urandom_range(600), $urandom_range(60), 20, 20);
    run_phase(PH_PRESSURE,    30,    20,   0,  0);
    run_phase(PH_LONG_TRACE,  100,   40,   0,  0);

    drain_results();
    repeat (4 * DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d samples in %0d traces (longest %0d), input stalled %0d cycles.",
             samples_sent, traces_sent, longest_trace, input_stalls);
    $display("Checked %0d results, %0d with pileup, over six register settings.",
             results_checked, pileup_results);
    if (errors == 0) begin
      $display("tb_trace_pulse_analyzer_unit OK");
    end else begin
      $display("tb_trace_pulse_analyzer_unit NOT OK");
    end
    $finish;
  end

endmodule

// File: trace_pulse_analyzer_unit.f
+incdir+rtl
rtl/tpa_pkg.sv
rtl/tpa_trace_acc.sv
rtl/tpa_result.sv
rtl/trace_pulse_analyzer_unit.sv
test/tb_trace_pulse_analyzer_unit.sv
